>>> hdl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, constants and types of the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int unsigned DATA_W        = 32;
    localparam int unsigned CNT_W         = $clog2(DATA_W);
    localparam int unsigned EXP_BITS      = 32;
    localparam int unsigned ADDR_W        = 3;
    localparam logic [DATA_W-1:0] MODULUS_RESET = 32'd1000000007;

    // register index, taken from paddr[2]
    localparam logic REG_MODULUS = 1'b0;

    // opcodes carried in tuser
    localparam logic OP_POWER   = 1'b0;
    localparam logic OP_INVERSE = 1'b1;

    // request to the serial modular multiplier: r = a * b mod m, a < m
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } t_mm_req;

    typedef struct packed {
        logic              done;
        logic              busy;
        logic [DATA_W-1:0] r;
    } t_mm_rsp;

endpackage

>>> hdl/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module mexp_mulmod
    import mexp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mm_req           i_req,
    input  logic [DATA_W-1:0] i_modulus,
    output t_mm_rsp           o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_a;
    logic [DATA_W-1:0] r_b;
    logic [DATA_W-1:0] r_r;

    logic [DATA_W+1:0] w_m;
    logic [DATA_W+1:0] w_t0;
    logic [DATA_W+1:0] w_t1;
    logic [DATA_W+1:0] w_t2;

    // r < m and a < m, so 2r + a < 3m: two conditional subtracts suffice
    always_comb begin
        w_m  = {2'b00, i_modulus};
        w_t0 = {1'b0, r_r, 1'b0} + (r_b[DATA_W-1] ? {2'b00, r_a} : '0);
        w_t1 = (w_t0 >= w_m) ? (w_t0 - w_m) : w_t0;
        w_t2 = (w_t1 >= w_m) ? (w_t1 - w_m) : w_t1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_cnt == CNT_W'(DATA_W - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
            r_r <= '0;
        end else if (r_busy) begin
            r_r <= w_t2[DATA_W-1:0];
            r_b <= {r_b[DATA_W-2:0], 1'b0};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.busy = r_busy;
    assign o_rsp.r    = r_r;

    property p_no_restart;
        @(posedge i_clk) disable iff (!i_rst_n) i_req.start |-> !r_busy;
    endproperty
    a_no_restart: assert property (p_no_restart) else $error("mulmod restarted while busy");

    property p_done_after_busy;
        @(posedge i_clk) disable iff (!i_rst_n) r_done |-> $past(r_busy);
    endproperty
    a_done_after_busy: assert property (p_done_after_busy) else $error("done without work");

    property p_residue;
        @(posedge i_clk) disable iff (!i_rst_n) r_done |-> (r_r < i_modulus);
    endproperty
    a_residue: assert property (p_residue) else $error("product not reduced");

endmodule

>>> hdl/modular_exponentiation_top.sv
// ----------------------------------------------------------------------------
// Products run one at a time on the bit-serial multiplier: one base
//   reduction, then per exponent bit a multiply when set and a square while set
//   bits remain above, none for a zero exponent or a modulus below 2.
// One item at a time: the next beat can be taken in the cycle after the
//   result enters the output register; a full, stalled output holds S_OUT.
// Synchronous active-low reset; modulus resets to 1000000007.
// ----------------------------------------------------------------------------
// modular_exponentiation_top
// Square-and-multiply sequencer around a shared serial modular multiplier.
// ----------------------------------------------------------------------------
module modular_exponentiation_top
    import mexp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // APB configuration
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [ADDR_W-1:0]  i_paddr,
    input  logic [DATA_W-1:0]  i_pwdata,
    output logic [DATA_W-1:0]  o_prdata,
    output logic               o_pready,
    // input stream
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [63:0]        i_s_axis_tdata,  // [31:0] base_value, [63:32] exponent
    input  logic [0:0]         i_s_axis_tuser,  // [0] opcode
    // output stream
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [DATA_W-1:0]  o_m_axis_tdata   // [31:0] result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_MUL,
        S_SQR,
        S_OUT
    } t_state;

    t_state               r_state;
    logic [DATA_W-1:0]    r_modulus;
    logic [DATA_W-1:0]    r_acc;
    logic [DATA_W-1:0]    r_sq;
    logic [EXP_BITS-1:0]  r_exp;
    logic                 r_mm_start;
    logic                 r_out_valid;
    logic [DATA_W-1:0]    r_out_data;

    t_mm_req              w_req;
    t_mm_rsp              w_rsp;
    logic                 w_in_beat;
    logic [DATA_W-1:0]    w_exp_eff;
    logic                 w_exp_more;

    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == REG_MODULUS) ? r_modulus : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MODULUS_RESET;
        end else if (i_psel && i_penable && i_pwrite && (i_paddr[2] == REG_MODULUS)) begin
            r_modulus <= i_pwdata;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_beat       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_exp_eff       = (i_s_axis_tuser[0] == OP_INVERSE) ? (r_modulus - DATA_W'(2))
                                                               : i_s_axis_tdata[63:32];
    assign w_exp_more      = (r_exp[EXP_BITS-1:1] != '0);

    always_comb begin
        w_req.start = r_mm_start;
        w_req.a     = r_sq;
        w_req.b     = r_acc;
        unique case (r_state)
            S_RED:   begin
                w_req.a = DATA_W'(1);
                w_req.b = r_sq;
            end
            S_SQR:   w_req.b = r_sq;
            default: w_req.b = r_acc;
        endcase
    end

    mexp_mulmod u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .i_modulus (r_modulus),
        .o_rsp     (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mm_start  <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_data  <= '0;
            r_acc       <= DATA_W'(1);
            r_sq        <= '0;
            r_exp       <= '0;
        end else begin
            if (r_state == S_OUT && (!r_out_valid || i_m_axis_tready)) begin
                r_out_valid <= 1'b1;
                r_out_data  <= r_acc;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_mm_start <= w_in_beat && (r_modulus >= DATA_W'(2)) &&
                                  (EXP_BITS'(w_exp_eff) != '0);
                    if (w_in_beat) begin
                        if (r_modulus < DATA_W'(2)) begin
                            r_acc   <= '0;
                            r_sq    <= '0;
                            r_exp   <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_acc <= DATA_W'(1);
                            r_sq  <= i_s_axis_tdata[31:0];
                            r_exp <= EXP_BITS'(w_exp_eff);
                            if (EXP_BITS'(w_exp_eff) == '0) begin
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_RED;
                            end
                        end
                    end
                end
                S_RED: begin
                    r_mm_start <= w_rsp.done;
                    if (w_rsp.done) begin
                        r_sq    <= w_rsp.r;
                        r_state <= r_exp[0] ? S_MUL : S_SQR;
                    end
                end
                S_MUL: begin
                    r_mm_start <= w_rsp.done && w_exp_more;
                    if (w_rsp.done) begin
                        r_acc   <= w_rsp.r;
                        r_state <= w_exp_more ? S_SQR : S_OUT;
                    end
                end
                S_SQR: begin
                    r_mm_start <= w_rsp.done;
                    if (w_rsp.done) begin
                        r_sq    <= w_rsp.r;
                        r_exp   <= {1'b0, r_exp[EXP_BITS-1:1]};
                        // a square is only issued while a set bit remains above
                        r_state <= r_exp[1] ? S_MUL : S_SQR;
                    end
                end
                S_OUT: begin
                    r_mm_start <= 1'b0;
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_exp   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_mm_start <= 1'b0;
                    r_state    <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    property p_busy_not_ready;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state != S_IDLE) |-> !o_s_axis_tready;
    endproperty
    a_busy_not_ready: assert property (p_busy_not_ready) else $error("ready while busy");

    property p_exp_live;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_MUL || r_state == S_SQR) |-> (r_exp != '0);
    endproperty
    a_exp_live: assert property (p_exp_live) else $error("product with exhausted exponent");

    property p_result_reduced;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_out_valid && r_modulus >= DATA_W'(2)) |-> (r_out_data < r_modulus);
    endproperty
    a_result_reduced: assert property (p_result_reduced) else $error("result not reduced");

    property p_start_pairs_done;
        @(posedge i_clk) disable iff (!i_rst_n)
            w_rsp.done |-> (r_state == S_RED || r_state == S_MUL || r_state == S_SQR);
    endproperty
    a_start_pairs_done: assert property (p_start_pairs_done) else $error("stray product");

    property p_busy_in_product;
        @(posedge i_clk) disable iff (!i_rst_n)
            w_rsp.busy |-> (r_state == S_RED || r_state == S_MUL || r_state == S_SQR);
    endproperty
    a_busy_in_product: assert property (p_busy_in_product) else $error("multiplier busy idle");

endmodule
